/* rtl/core/fas_pkg.sv */
// Package for the FIFO address stash: sizes, operation codes and word types.
// Used by fas_cell and fifo_address_stash; depends on nothing else.
package fas_pkg;

   // Number of cells in the stash.
   localparam int DEPTH    = 16;
   localparam int ADDR_W   = 64;
   localparam int CAP_W    = 5;
   localparam int OCC_W    = 5;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Operation codes carried in the request word.
   typedef enum logic [1:0] {
      FUNC_LOOKUP        = 2'd0,
      FUNC_INSERT        = 2'd1,
      FUNC_INSERT_UNIQUE = 2'd2,
      FUNC_EJECT         = 2'd3
   } func_type;

   // Request word.
   typedef struct packed {
      func_type            func;
      logic [ADDR_W-1:0]   addr;
   } req_type;

   // Response word.
   typedef struct packed {
      logic                hit;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // Update controls broadcast to every cell.
   typedef struct packed {
      logic insert_en;
      logic eject_en;
   } fas_ctrl_type;

endpackage

/* rtl/core/fas_cell.sv */
// One stash cell: holds a single address, compares it and shifts toward either neighbor.
// Depends on fas_pkg for widths and the control struct.
module fas_cell
   import fas_pkg::*;
(
   input  logic                clock,
   input  fas_ctrl_type        ctrl,
   input  logic [ADDR_W-1:0]   req_addr,
   input  logic [ADDR_W-1:0]   prev_entry,
   input  logic [ADDR_W-1:0]   next_entry,
   input  logic                valid,
   input  logic                match_before,
   output logic [ADDR_W-1:0]   entry,
   output logic                match_through
);

   logic [ADDR_W-1:0] entry_ff;
   logic [ADDR_W-1:0] entry_in;
   logic              match;

   // A cell matches only while it lies inside the filled region.
   assign match         = valid && (entry_ff == req_addr);
   assign match_through = match_before || match;
   assign entry         = entry_ff;

   // Insert moves every word one cell toward the old end; eject closes the gap
   // from the first matching cell onward.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         entry_in = prev_entry;
      end else if (ctrl.eject_en && match_through) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* rtl/core/fifo_address_stash.sv */
// Top level of the FIFO address stash: a row of fas_cell instances plus fill and
// capacity control. Depends on fas_pkg and fas_cell.
// The response word is strobed in the cycle after the request is taken.
// Throughput: one request per cycle while busy is low; compare, priority chain and shift complete in that same cycle.
// busy is high only while reset is asserted; the response cannot be stalled.
// Reset empties the stash and sets the capacity register to the full depth.
module fifo_address_stash
   import fas_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_word,
   output logic             rsp_strobe,
   output rsp_type          rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   logic               accept;
   logic [CAP_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic [CMP_W-1:0]   cap_eff;
   logic               hit;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;
   fas_ctrl_type       ctrl;

   logic [ADDR_W-1:0]  cell_entry [DEPTH];
   logic [DEPTH:0]     match_chain;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(DEPTH > 31 ? 31 : DEPTH);
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   // Capacity above the depth is treated as the depth.
   assign cap_eff = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(capacity_ff);

   // Cell row; the match chain carries "some newer cell matched" toward the old end.
   assign match_chain[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ADDR_W-1:0] prev_entry;
      logic [ADDR_W-1:0] next_entry;
      logic              valid;

      if (i == 0) begin : g_first
         assign prev_entry = req_word.addr;
      end else begin : g_mid
         assign prev_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      assign valid = fill_ff > CNT_W'(i);

      fas_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .req_addr      (req_word.addr),
         .prev_entry    (prev_entry),
         .next_entry    (next_entry),
         .valid         (valid),
         .match_before  (match_chain[i]),
         .entry         (cell_entry[i]),
         .match_through (match_chain[i+1])
      );
   end

   assign hit = match_chain[DEPTH];

   // Operation decode into cell controls.
   always_comb begin
      ctrl = '0;
      unique case (req_word.func)
         FUNC_LOOKUP:        ctrl = '0;
         FUNC_INSERT:        ctrl.insert_en = accept;
         FUNC_INSERT_UNIQUE: ctrl.insert_en = accept && !hit;
         FUNC_EJECT:         ctrl.eject_en  = accept && hit;
         default:            ctrl = '0;
      endcase
   end

   // Fill count: an insert grows it while below capacity, an eject with a hit shrinks it.
   always_comb begin
      fill_in = fill_ff;
      if (ctrl.insert_en && (CMP_W'(fill_ff) < cap_eff)) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (ctrl.eject_en) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rsp_strobe_ff <= accept;
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.hit       <= hit;
         rsp_ff.occupancy <= OCC_W'(fill_in);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   // Every accepted request gives one response in the next cycle, and no other.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe) else $error("missing response after accepted request");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe) else $error("response without request");

   // The fill count never exceeds the number of cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(DEPTH)) else $error("fill count above depth");

   // An eject that hits removes exactly one entry.
   a_eject_dec: assert property (@(posedge clock) disable iff (reset)
      ctrl.eject_en |=> fill_ff == $past(fill_ff) - CNT_W'(1))
      else $error("eject did not remove one entry");

   // A lookup leaves the fill count alone.
   a_lookup_stable: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.func == FUNC_LOOKUP) |=> $stable(fill_ff))
      else $error("lookup changed the fill count");

endmodule
